### rtl/tsm_pkg.sv
// Package for the two-stack machine executor: sizes, opcodes, error codes
// and the request/result payload types. No dependencies.
package tsm_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int RET_DEPTH   = 64;
  localparam int DATA_WORDS  = 1024;
  localparam int CODE_WORDS  = 4096;

  localparam int DSP_W = $clog2(STACK_DEPTH);
  localparam int DTOP_W = DSP_W + 1;
  localparam int RSP_W = $clog2(RET_DEPTH);
  localparam int RTOP_W = RSP_W + 1;
  localparam int DA_W = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int PC_W = 12;

  localparam logic [31:0] CHAR_NEWLINE = 32'd10;
  localparam logic [31:0] CHAR_SPACE   = 32'd32;

  typedef enum logic [7:0] {
    OP_ADD = 8'd0, OP_SUB = 8'd1, OP_MUL = 8'd2, OP_DIV = 8'd3,
    OP_PUSH = 8'd4, OP_POP = 8'd5, OP_NL = 8'd6, OP_ZERO = 8'd7,
    OP_SPACE = 8'd8, OP_LOAD = 8'd9, OP_WRITE = 8'd10, OP_INI = 8'd11,
    OP_INC = 8'd12, OP_OUTI = 8'd13, OP_OUTC = 8'd14, OP_JMP = 8'd15,
    OP_JZ = 8'd16, OP_JN = 8'd17, OP_CALL = 8'd18, OP_RET = 8'd19,
    OP_HALT = 8'd20
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0, ERR_DSTK = 3'd1, ERR_RSTK = 3'd2, ERR_DADDR = 3'd3,
    ERR_CADDR = 3'd4, ERR_OP = 3'd5, ERR_DIV0 = 3'd6
  } err_t;

  typedef struct packed {
    logic [7:0]         op;
    logic signed [31:0] arg;
    logic signed [31:0] in_value;
  } req_t;

  typedef struct packed {
    logic [11:0]        next_addr;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic               out_is_char;
    logic               halted;
    logic [2:0]         error;
  } res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_req;   // capture request, launch stack reads
    logic exec;       // evaluate instruction, start divider if needed
    logic commit;     // write back state and build result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_busy;
    logic clearing;   // data segment clearing pass after reset
  } sts_t;

endpackage

### rtl/tsm_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
module tsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/tsm_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing but its ports.
module tsm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, busy_r, busy_nxt;
  logic [32:0] trial;
  logic [31:0] ad, ab;

  assign ad = dividend[31] ? (~dividend + 32'd1) : dividend;
  assign ab = divisor[31] ? (~divisor + 32'd1) : divisor;
  assign trial = {rem_r, quo_r[31]} - {1'b0, dvs_r};

  // Restoring division step.
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      if (trial[32]) begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= 6'd32;
      rem_r <= '0;
      quo_r <= ad;
      dvs_r <= ab;
      neg_r <= dividend[31] ^ divisor[31];
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign quotient = neg_r ? (~quo_r + 32'd1) : quo_r;
endmodule

### rtl/tsm_datapath.sv
// Datapath of the stack machine: stacks, data segment, registers, ALU.
// Depends on tsm_pkg, tsm_ram and tsm_div.
module tsm_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  tsm_pkg::req_t  req,
  input  tsm_pkg::cmd_t  cmd,
  output tsm_pkg::sts_t  sts,
  output tsm_pkg::res_t  res
);
  localparam int DSP_W = tsm_pkg::DSP_W;
  localparam int DTOP_W = tsm_pkg::DTOP_W;
  localparam int RSP_W = tsm_pkg::RSP_W;
  localparam int RTOP_W = tsm_pkg::RTOP_W;
  localparam int DA_W = tsm_pkg::DA_W;
  localparam int PC_W = tsm_pkg::PC_W;

  tsm_pkg::req_t req_r;
  logic [DTOP_W-1:0] dtop_r, dtop_nxt;
  logic [RTOP_W-1:0] rtop_r, rtop_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic              halt_r;
  tsm_pkg::err_t     err_r, e;
  // Clearing pass state: one data segment word is zeroed per cycle.
  logic              clr_r;
  logic [DA_W-1:0]   clr_a_r;

  logic [31:0] x_rd, y_rd, seg_rd, seg_wd;
  logic [11:0] r_rd;
  logic        ds_we, seg_we, rs_we;
  logic [DSP_W-1:0] ds_wa, x_ra, y_ra;
  logic [31:0] ds_wd;
  logic [RSP_W-1:0] rs_wa, rs_ra;
  logic [DA_W-1:0]  seg_a, seg_ra;

  // Evaluated decision, held from exec to commit.
  logic        pushv_r, wr_r, rpush_r, rpop_r, hlt_r, ov_r, oc_r, isdiv_r;
  logic [1:0]  pops_r;
  logic [31:0] pv_r, oval_r;
  logic [PC_W-1:0] nxt_r;
  tsm_pkg::err_t   e_r;

  logic        pushv, wr, rpush, rpop, hlt, ov, oc, isdiv;
  logic [1:0]  pops;
  logic [31:0] pv, oval, prod;
  logic signed [33:0] nxt;
  logic        active, argop, argfail, dok;
  logic        div_busy;
  logic [31:0] quot;

  assign x_ra = DSP_W'(dtop_r - DTOP_W'(1));
  assign y_ra = DSP_W'(dtop_r - DTOP_W'(2));
  assign rs_ra = RSP_W'(rtop_r - RTOP_W'(1));
  assign seg_ra = DA_W'(req.arg);

  tsm_ram #(.WIDTH(32), .DEPTH(tsm_pkg::STACK_DEPTH)) u_dsx (
    .clk(clk), .we(ds_we), .waddr(ds_wa), .wdata(ds_wd), .raddr(x_ra), .rdata(x_rd));
  tsm_ram #(.WIDTH(32), .DEPTH(tsm_pkg::STACK_DEPTH)) u_dsy (
    .clk(clk), .we(ds_we), .waddr(ds_wa), .wdata(ds_wd), .raddr(y_ra), .rdata(y_rd));
  tsm_ram #(.WIDTH(12), .DEPTH(tsm_pkg::RET_DEPTH)) u_rs (
    .clk(clk), .we(rs_we), .waddr(rs_wa), .wdata(12'(pc_r + PC_W'(1))),
    .raddr(rs_ra), .rdata(r_rd));
  tsm_ram #(.WIDTH(32), .DEPTH(tsm_pkg::DATA_WORDS)) u_seg (
    .clk(clk), .we(seg_we), .waddr(seg_a), .wdata(seg_wd), .raddr(seg_ra),
    .rdata(seg_rd));

  tsm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.exec && isdiv && e == tsm_pkg::ERR_NONE),
    .dividend(y_rd), .divisor(x_rd), .busy(div_busy), .quotient(quot));
  assign sts.div_busy = div_busy;
  assign sts.clearing = clr_r;

  assign prod = x_rd * y_rd;

  // Instruction decode and checks.
  always_comb begin
    e = tsm_pkg::ERR_NONE;
    pops = 2'd0; pushv = 1'b0; pv = '0; wr = 1'b0; rpush = 1'b0; rpop = 1'b0;
    hlt = 1'b0; ov = 1'b0; oc = 1'b0; oval = '0; isdiv = 1'b0;
    active = !halt_r && err_r == tsm_pkg::ERR_NONE;
    argop = req_r.op inside {tsm_pkg::OP_PUSH, tsm_pkg::OP_LOAD, tsm_pkg::OP_WRITE,
                             tsm_pkg::OP_JMP, tsm_pkg::OP_JZ, tsm_pkg::OP_JN,
                             tsm_pkg::OP_CALL};
    argfail = (34'(pc_r) + 34'sd1) >= 34'(tsm_pkg::CODE_WORDS);
    dok = !req_r.arg[31] && (33'(req_r.arg) < 33'(tsm_pkg::DATA_WORDS));
    nxt = 34'(pc_r) + (argop ? 34'sd2 : 34'sd1);
    case (req_r.op)
      tsm_pkg::OP_ADD, tsm_pkg::OP_SUB, tsm_pkg::OP_MUL, tsm_pkg::OP_DIV: begin
        if (dtop_r < DTOP_W'(2)) e = tsm_pkg::ERR_DSTK;
        else begin
          pops = 2'd2; pushv = 1'b1;
          case (req_r.op)
            tsm_pkg::OP_ADD: pv = x_rd + y_rd;
            tsm_pkg::OP_SUB: pv = y_rd - x_rd;
            tsm_pkg::OP_MUL: pv = prod;
            default: begin
              if (x_rd == '0) e = tsm_pkg::ERR_DIV0;
              else isdiv = 1'b1;
            end
          endcase
        end
      end
      tsm_pkg::OP_PUSH, tsm_pkg::OP_LOAD: begin
        if (argfail) e = tsm_pkg::ERR_CADDR;
        else if (req_r.op == 8'(tsm_pkg::OP_LOAD) && !dok) e = tsm_pkg::ERR_DADDR;
        else if (dtop_r >= DTOP_W'(tsm_pkg::STACK_DEPTH)) e = tsm_pkg::ERR_DSTK;
        else begin
          pushv = 1'b1;
          pv = (req_r.op == 8'(tsm_pkg::OP_PUSH)) ? req_r.arg : seg_rd;
        end
      end
      tsm_pkg::OP_POP, tsm_pkg::OP_OUTI, tsm_pkg::OP_OUTC: begin
        if (dtop_r == '0) e = tsm_pkg::ERR_DSTK;
        else begin
          pops = 2'd1;
          if (req_r.op != 8'(tsm_pkg::OP_POP)) begin
            ov = 1'b1; oc = req_r.op == 8'(tsm_pkg::OP_OUTC); oval = x_rd;
          end
        end
      end
      tsm_pkg::OP_NL, tsm_pkg::OP_ZERO, tsm_pkg::OP_SPACE, tsm_pkg::OP_INI,
      tsm_pkg::OP_INC: begin
        if (dtop_r >= DTOP_W'(tsm_pkg::STACK_DEPTH)) e = tsm_pkg::ERR_DSTK;
        else begin
          pushv = 1'b1;
          case (req_r.op)
            tsm_pkg::OP_NL: pv = tsm_pkg::CHAR_NEWLINE;
            tsm_pkg::OP_ZERO: pv = '0;
            tsm_pkg::OP_SPACE: pv = tsm_pkg::CHAR_SPACE;
            tsm_pkg::OP_INI: pv = req_r.in_value;
            default: pv = {{24{req_r.in_value[7]}}, req_r.in_value[7:0]};
          endcase
        end
      end
      tsm_pkg::OP_WRITE: begin
        if (dtop_r == '0) e = tsm_pkg::ERR_DSTK;
        else if (argfail) e = tsm_pkg::ERR_CADDR;
        else if (!dok) e = tsm_pkg::ERR_DADDR;
        else begin
          pops = 2'd1; wr = 1'b1;
        end
      end
      tsm_pkg::OP_JMP: begin
        if (argfail) e = tsm_pkg::ERR_CADDR;
        else nxt = 34'(pc_r) + 34'sd1 + 34'(req_r.arg);
      end
      tsm_pkg::OP_JZ, tsm_pkg::OP_JN: begin
        if (dtop_r == '0) e = tsm_pkg::ERR_DSTK;
        else if (argfail) e = tsm_pkg::ERR_CADDR;
        else begin
          pops = 2'd1;
          if ((req_r.op == 8'(tsm_pkg::OP_JZ)) ? (x_rd == '0) : x_rd[31])
            nxt = 34'(pc_r) + 34'sd1 + 34'(req_r.arg);
        end
      end
      tsm_pkg::OP_CALL: begin
        if (argfail) e = tsm_pkg::ERR_CADDR;
        else if (rtop_r >= RTOP_W'(tsm_pkg::RET_DEPTH)) e = tsm_pkg::ERR_RSTK;
        else begin
          rpush = 1'b1; nxt = 34'(pc_r) + 34'(req_r.arg);
        end
      end
      tsm_pkg::OP_RET: begin
        if (rtop_r == '0) e = tsm_pkg::ERR_RSTK;
        else begin
          rpop = 1'b1; nxt = 34'(r_rd) + 34'sd1;
        end
      end
      tsm_pkg::OP_HALT: begin
        hlt = 1'b1; nxt = 34'(pc_r);
      end
      default: e = tsm_pkg::ERR_OP;
    endcase
    if (e == tsm_pkg::ERR_NONE && (nxt < 0 || nxt >= 34'(tsm_pkg::CODE_WORDS)))
      e = tsm_pkg::ERR_CADDR;
    if (!active) begin
      e = tsm_pkg::ERR_NONE;
      pops = 2'd0; pushv = 1'b0; wr = 1'b0; rpush = 1'b0; rpop = 1'b0;
      hlt = 1'b0; ov = 1'b0; oc = 1'b0; oval = '0; isdiv = 1'b0;
      nxt = 34'(pc_r);
    end
    if (e != tsm_pkg::ERR_NONE) begin
      ov = 1'b0; oc = 1'b0; oval = '0;
    end
  end

  // Clearing pass: after reset every data segment word is written with zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      clr_a_r <= '0;
    end else if (clr_r) begin
      clr_a_r <= clr_a_r + DA_W'(1);
      if (clr_a_r == DA_W'(tsm_pkg::DATA_WORDS - 1)) clr_r <= 1'b0;
    end
  end

  // Write-back from the held decision.
  logic ok_c;
  assign ok_c = cmd.commit && e_r == tsm_pkg::ERR_NONE;
  assign dtop_nxt = dtop_r - DTOP_W'(pops_r) + DTOP_W'(pushv_r);
  assign ds_we = ok_c && pushv_r;
  assign ds_wa = DSP_W'(dtop_r - DTOP_W'(pops_r));
  assign ds_wd = isdiv_r ? quot : pv_r;
  assign seg_we = clr_r || (ok_c && wr_r);
  assign seg_a = clr_r ? clr_a_r : DA_W'(req_r.arg);
  assign seg_wd = clr_r ? 32'd0 : x_rd;
  assign rs_we = ok_c && rpush_r;
  assign rs_wa = RSP_W'(rtop_r);
  assign rtop_nxt = rtop_r + RTOP_W'(rpush_r) - RTOP_W'(rpop_r);
  assign pc_nxt = nxt_r;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= req;
    end
    if (cmd.exec) begin
      pops_r <= pops; pushv_r <= pushv; pv_r <= pv; wr_r <= wr; rpush_r <= rpush;
      rpop_r <= rpop; hlt_r <= hlt; ov_r <= ov; oc_r <= oc; oval_r <= oval;
      isdiv_r <= isdiv; nxt_r <= PC_W'(nxt); e_r <= e;
    end
    if (!rst_n) begin
      dtop_r <= '0; rtop_r <= '0; pc_r <= '0; halt_r <= 1'b0;
      err_r <= tsm_pkg::ERR_NONE;
    end else if (cmd.commit) begin
      res.out_valid <= ov_r; res.out_value <= oval_r; res.out_is_char <= oc_r;
      if (e_r != tsm_pkg::ERR_NONE) begin
        err_r <= e_r;
        res.error <= e_r; res.next_addr <= pc_r; res.halted <= halt_r;
      end else begin
        dtop_r <= dtop_nxt; rtop_r <= rtop_nxt; pc_r <= pc_nxt;
        if (hlt_r) halt_r <= 1'b1;
        res.error <= err_r; res.next_addr <= pc_nxt; res.halted <= halt_r | hlt_r;
      end
    end
  end
endmodule

### rtl/tsm_ctrl.sv
// Controller of the stack machine: request handshake and instruction sequencing.
// Depends on tsm_pkg.
module tsm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  tsm_pkg::sts_t sts,
  output tsm_pkg::cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DIV, S_COMMIT} state_t;
  state_t state_r;
  logic   ov_r;
  logic   take;

  assign take = in_valid && !in_stall;
  assign in_stall = sts.clearing || (state_r != S_IDLE) || (ov_r && out_stall);
  assign out_valid = ov_r;
  assign cmd.load_req = take;
  assign cmd.exec = state_r == S_EXEC;
  assign cmd.commit = state_r == S_COMMIT;

  // Sequencer and result-valid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (take) state_r <= S_EXEC;
        S_EXEC: state_r <= S_DIV;
        S_DIV: if (!sts.div_busy) state_r <= S_COMMIT;
        S_COMMIT: begin
          state_r <= S_IDLE;
          ov_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/two_stack_machine_executor_core.sv
// Top level of the two-stack machine executor.
// Depends on tsm_pkg, tsm_ctrl and tsm_datapath.
//
//   channel   direction  ports
//   request   in         in_valid, in_stall, in_data (tsm_pkg::req_t)
//   result    out        out_valid, out_stall, out_data (tsm_pkg::res_t)
//
// An instruction goes from acceptance to result through the evaluate, divider
// wait and write-back states; a divide waits there for the serial divider.
// A new request is accepted only once the machine is idle and the result
// register is free or being taken.
// After reset a clearing pass zeroes all 1024 data segment words while the
// request channel stalls; reset also empties both stacks.
module two_stack_machine_executor_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tsm_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tsm_pkg::res_t out_data
);
  tsm_pkg::cmd_t cmd;
  tsm_pkg::sts_t sts;

  tsm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd));

  tsm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .req(in_data), .cmd(cmd), .sts(sts), .res(out_data));
endmodule
